FILE: rtl/dsvm_pkg.sv
// Shared types, codes and constants of the delayed stereo voice mixer.
`default_nettype none

package dsvm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int DELAY_W     = 16;
    localparam int DELAY_MAX   = 45114;   // largest delay in samples, 1023 ms
    localparam int LEN_IN_MAX  = 131071;  // largest length the input field can carry
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 3;

    typedef logic [2:0] op_t;
    localparam op_t OP_WORD    = 3'd0;
    localparam op_t OP_LEN     = 3'd1;
    localparam op_t OP_VOICE   = 3'd2;
    localparam op_t OP_RESTART = 3'd3;
    localparam op_t OP_FRAME   = 3'd4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_VOICE_COUNT = 1'b0;
    localparam cfg_idx_t CFG_LOOP_CLIP   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic [DELAY_W-1:0]         delay_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    // ms * 44100 / 1000 = 44 * ms + ms / 10; the tenth is a reciprocal multiply,
    // exact for every 10-bit value.
    function automatic delay_t ms_to_samples(input logic [9:0] ms);
        logic [17:0] tenth;
        tenth = 18'(ms) * 18'd205;
        return delay_t'(16'(ms) * 16'd44 + 16'(tenth >> 11));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/delayed_stereo_voice_mixer.sv
// Delayed stereo voice mixer top level: clip memory, voice table and frame sequencer.
// Items arrive on the s_axis channel with the operation in tuser: clip word writes,
// clip length writes, voice writes and restart give no transfer out. A frame request
// gives one stereo transfer on m_axis. A frame clears both sums, checks playback,
// then for each active voice reads its sample, does the two channel multiplies and
// accumulates, and then loads the output register. When playback is idle a frame
// skips the voices and gives zeros. The result waits in an output register, so
// further items are taken while it stalls; a frame only finishes once that register
// is free. Clip memory holds NUM_CLIPS * CLIP_DEPTH samples with undefined contents
// after reset; reading a word never written yields an arbitrary sample. There is no
// clearing pass. The user must write configuration (voice_count, loop_clip) through
// cfg_we only while the block is idle; the block itself does not enforce this.
`default_nettype none

module delayed_stereo_voice_mixer #(
    parameter int unsigned NUM_CLIPS  = 5,
    parameter int unsigned NUM_VOICES = 5,
    parameter int unsigned CLIP_DEPTH = 65536
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // clip_sel[2:0] word_addr[18:3] word_value[34:19] clip_len[51:35] voice_sel[54:52]
    // gain_left[70:55] gain_right[86:71] delay_ms[96:87], zero fill above
    input  wire  [dsvm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // operation[2:0]
    input  wire  [2:0]                            s_axis_tuser,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // left_out[15:0] right_out[31:16]
    output logic [dsvm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    input  wire                                   cfg_we,
    input  wire  [dsvm_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire  [dsvm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import dsvm_pkg::*;

    localparam int unsigned MEM_DEPTH = NUM_CLIPS * CLIP_DEPTH;
    localparam int MEM_AW  = $clog2(MEM_DEPTH);
    localparam int LEN_MAX = (CLIP_DEPTH < LEN_IN_MAX) ? CLIP_DEPTH : LEN_IN_MAX;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);
    localparam int POS_W   = $clog2(LEN_MAX + DELAY_MAX + 1);
    localparam int CIDX_W  = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
    localparam int VIDX_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_END   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // input fields
    op_t         op;
    logic [2:0]  clip_sel;
    logic [15:0] word_addr;
    logic [15:0] word_value;
    logic [16:0] clip_len;
    logic [2:0]  voice_sel;
    gain_t       gain_left;
    gain_t       gain_right;
    logic [9:0]  delay_ms;

    assign op         = s_axis_tuser;
    assign clip_sel   = s_axis_tdata[2:0];
    assign word_addr  = s_axis_tdata[18:3];
    assign word_value = s_axis_tdata[34:19];
    assign clip_len   = s_axis_tdata[51:35];
    assign voice_sel  = s_axis_tdata[54:52];
    assign gain_left  = s_axis_tdata[70:55];
    assign gain_right = s_axis_tdata[86:71];
    assign delay_ms   = s_axis_tdata[96:87];

    // configuration
    logic [2:0] voice_count_reg;
    logic [2:0] loop_clip_reg;

    // voice table and clip lengths, cleared by reset
    logic [2:0]       v_clip_reg  [NUM_VOICES];
    delay_t           v_delay_reg [NUM_VOICES];
    gain_t            v_gl_reg    [NUM_VOICES];
    gain_t            v_gr_reg    [NUM_VOICES];
    logic [LEN_W-1:0] len_reg     [NUM_CLIPS];

    // clip memory
    logic [SAMPLE_W-1:0] clip_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                wr_en;
    logic [MEM_AW-1:0]   wr_addr;
    logic                rd_en;
    logic [MEM_AW-1:0]   rd_addr;

    // sequencer
    logic [2:0]        state_reg,    state_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic              playing_reg,  playing_next;
    logic [POS_W-1:0]  end_reg,      end_next;
    logic [VIDX_W-1:0] vidx_reg,     vidx_next;
    logic              in_range_reg, in_range_next;
    logic              m_valid_reg,  m_valid_next;
    sample_t           left_reg;
    sample_t           right_reg;

    logic              accept;
    logic              out_free;
    logic [3:0]        n_act;
    delay_t            max_delay;
    logic [LEN_W-1:0]  base_len;
    logic              last_voice;

    // current voice fetch
    logic [2:0]        cur_clip;
    logic [CIDX_W-1:0] cur_cidx;
    delay_t            cur_delay;
    logic [POS_W-1:0]  cur_idx;

    mac_ctrl_t mac_ctrl;
    sample_t   mac_sample;
    sample_t   left_acc;
    sample_t   right_acc;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign n_act         = (32'(voice_count_reg) > NUM_VOICES) ? 4'(NUM_VOICES)
                                                               : 4'(voice_count_reg);
    assign last_voice    = (32'(vidx_reg) + 32'd1 >= 32'(n_act));

    // largest delay over the active voices
    always_comb
    begin
        max_delay = '0;
        for (int i = 0; i < int'(NUM_VOICES); i++)
        begin
            if ((i < int'(n_act)) && (v_delay_reg[i] > max_delay))
            begin
                max_delay = v_delay_reg[i];
            end
        end
    end

    always_comb
    begin
        if (32'(loop_clip_reg) < NUM_CLIPS)
        begin
            base_len = len_reg[loop_clip_reg[CIDX_W-1:0]];
        end
        else
        begin
            base_len = '0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_count_reg <= 3'd0;
            loop_clip_reg   <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_VOICE_COUNT: voice_count_reg <= cfg_wdata;
                CFG_LOOP_CLIP:   loop_clip_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // voice table and length writes; drop out-of-range selectors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(NUM_VOICES); i++)
            begin
                v_clip_reg[i]  <= '0;
                v_delay_reg[i] <= '0;
                v_gl_reg[i]    <= '0;
                v_gr_reg[i]    <= '0;
            end
            for (int c = 0; c < int'(NUM_CLIPS); c++)
            begin
                len_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            if ((op == OP_VOICE) && (32'(voice_sel) < NUM_VOICES))
            begin
                v_clip_reg[voice_sel[VIDX_W-1:0]]  <= clip_sel;
                v_delay_reg[voice_sel[VIDX_W-1:0]] <= ms_to_samples(delay_ms);
                v_gl_reg[voice_sel[VIDX_W-1:0]]    <= gain_left;
                v_gr_reg[voice_sel[VIDX_W-1:0]]    <= gain_right;
            end
            if ((op == OP_LEN) && (32'(clip_sel) < NUM_CLIPS))
            begin
                if (32'(clip_len) > 32'(LEN_MAX))
                begin
                    len_reg[clip_sel[CIDX_W-1:0]] <= LEN_W'(LEN_MAX);
                end
                else
                begin
                    len_reg[clip_sel[CIDX_W-1:0]] <= LEN_W'(clip_len);
                end
            end
        end
    end

    // clip memory port: word writes while idle, sample reads while mixing
    assign wr_en   = accept && (op == OP_WORD) && (32'(clip_sel) < NUM_CLIPS)
                     && (32'(word_addr) < CLIP_DEPTH);
    assign wr_addr = MEM_AW'(32'(clip_sel) * CLIP_DEPTH + 32'(word_addr));

    assign cur_clip  = v_clip_reg[vidx_reg];
    assign cur_cidx  = cur_clip[CIDX_W-1:0];
    assign cur_delay = v_delay_reg[vidx_reg];
    assign cur_idx   = POS_W'(32'(pos_reg) - 32'(cur_delay));
    assign rd_en     = (state_reg == S_READ);
    assign rd_addr   = MEM_AW'(32'(cur_cidx) * CLIP_DEPTH + 32'(cur_idx));

    always_comb
    begin
        in_range_next = in_range_reg;
        if (rd_en)
        begin
            in_range_next = (32'(cur_clip) < NUM_CLIPS)
                            && (32'(pos_reg) >= 32'(cur_delay))
                            && (32'(cur_idx) < 32'(len_reg[cur_cidx]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            clip_mem[wr_addr] <= word_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= clip_mem[rd_addr];
        end
    end

    // frame sequencer
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        playing_next = playing_reg;
        end_next     = end_reg;
        vidx_next    = vidx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        mac_ctrl     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_RESTART))
                begin
                    playing_next = 1'b1;
                    pos_next     = '0;
                end
                if (accept && (op == OP_FRAME))
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                // hold the end of play and clear both sums
                end_next       = POS_W'(32'(base_len) + 32'(max_delay));
                mac_ctrl.clear = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                vidx_next = '0;
                if (playing_reg && (32'(pos_reg) + 32'd1 >= 32'(end_reg)))
                begin
                    playing_next = 1'b0;
                    state_next   = S_OUT;
                end
                else if (playing_reg && (n_act != 4'd0))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                state_next      = S_ACC;
            end
            S_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                if (last_voice)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free, then advance playback
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (playing_reg)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            playing_reg  <= 1'b0;
            end_reg      <= '0;
            vidx_reg     <= '0;
            in_range_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            playing_reg  <= playing_next;
            end_reg      <= end_next;
            vidx_reg     <= vidx_next;
            in_range_reg <= in_range_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            left_reg  <= left_acc;
            right_reg <= right_acc;
        end
    end

    // out-of-range reads contribute nothing
    assign mac_sample = in_range_reg ? sample_t'(rd_data_reg) : '0;

    dsvm_mac u_mac_left (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .gain   (v_gl_reg[vidx_reg]),
        .acc    (left_acc)
    );

    dsvm_mac u_mac_right (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .gain   (v_gr_reg[vidx_reg]),
        .acc    (right_acc)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {right_reg, left_reg};

`ifndef SYNTHESIS
    a_read_only_while_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> playing_reg)
        else $error("clip read issued while playback idle");

    a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_FRAME)) |=> (state_reg == S_END))
        else $error("frame transfer did not start the sequencer");

    a_voice_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (32'(vidx_reg) < 32'(n_act)))
        else $error("voice index beyond active voices");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free) |=> (m_valid_reg && (state_reg == S_IDLE)))
        else $error("frame result not presented");

    a_pos_moves_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_OUT) && !(accept && (op == OP_RESTART))) |=> $stable(pos_reg))
        else $error("play position changed outside a frame or restart");
`endif

endmodule

`default_nettype wire

FILE: rtl/dsvm_mac.sv
// One channel: gain multiply, then truncating and saturating accumulate.
`default_nettype none

module dsvm_mac (
    input  wire                  clk,
    input  dsvm_pkg::mac_ctrl_t  ctrl,
    input  dsvm_pkg::sample_t    sample,
    input  dsvm_pkg::gain_t      gain,
    output dsvm_pkg::sample_t    acc
);
    import dsvm_pkg::*;

    logic signed [31:0] prod_reg;
    sample_t            acc_reg;
    sample_t            acc_next;
    logic signed [33:0] sum;
    logic signed [21:0] quot;

    always_comb
    begin
        sum  = {{6{acc_reg[15]}}, acc_reg, 12'b0} + {{2{prod_reg[31]}}, prod_reg};
        quot = sum[33:12];
        // round toward zero for negative sums with a fraction
        if (sum[33] && (sum[11:0] != 12'd0))
        begin
            quot = quot + 22'sd1;
        end
        if (quot > 22'sd32767)
        begin
            acc_next = 16'sh7FFF;
        end
        else if (quot < -22'sd32768)
        begin
            acc_next = -16'sh8000;
        end
        else
        begin
            acc_next = quot[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= sample * gain;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire
